// ===== design/wepl_pkg.sv =====
// Shared types, sizes and ring-slot helper for the windowed event pair lag core.
// No dependencies; imported by wepl_out_stage and windowed_event_pair_lags_core.
`default_nettype none

package wepl_pkg;

   localparam int WINDOW_DEPTH  = 32;
   localparam int TIME_BITS     = 32;
   localparam int LABEL_BITS    = 8;
   localparam int LAG_BITS      = 16;
   localparam int DIFF_BITS     = LAG_BITS + 1;
   localparam int SLOT_BITS     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int COUNT_BITS    = $clog2(WINDOW_DEPTH + 1);
   localparam int ENTRY_BITS    = TIME_BITS + LABEL_BITS;
   localparam int REQ_DATA_BITS = ((TIME_BITS + LABEL_BITS + 7) / 8) * 8;
   localparam int RSP_RAW_BITS  = 2 * LABEL_BITS + DIFF_BITS;
   localparam int RSP_DATA_BITS = ((RSP_RAW_BITS + 7) / 8) * 8;

   typedef logic [TIME_BITS-1:0]  time_type;
   typedef logic [LABEL_BITS-1:0] label_type;
   typedef logic [LAG_BITS-1:0]   lag_type;
   typedef logic [SLOT_BITS-1:0]  slot_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   typedef struct packed {
      label_type                    first_label;
      label_type                    second_label;
      logic signed [DIFF_BITS-1:0]  time_difference;
      logic                         last_of_run;
      logic                         window_overflowed;
   } rsp_item_type;

   // Ring position base + offset, offset no larger than the depth.
   function automatic slot_type slot_add(input slot_type base, input count_type offset);
      logic [COUNT_BITS:0] sum;
      sum = (COUNT_BITS+1)'(base) + (COUNT_BITS+1)'(offset);
      if (sum >= (COUNT_BITS+1)'(WINDOW_DEPTH)) begin
         sum = sum - (COUNT_BITS+1)'(WINDOW_DEPTH);
      end
      return slot_type'(sum);
   endfunction

endpackage

`default_nettype wire

// ===== design/windowed_event_pair_lags_core.sv =====
// Windowed event pair lag core: ring window of recent events in one memory; depends on wepl_pkg
// and wepl_out_stage. Per event: each stored entry is read and judged, each matching entry gives
// a pair of mirrored results, and then the new event is stored into the ring.
// The window memory read and the single output register set the rate;
// one event at a time, and the next event is accepted while the last result still waits.
// Synchronous reset clears control state, head/count, overflow flag and lag; memory is not cleared.
`default_nettype none

module windowed_event_pair_lags_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration: max_time_lag
   input  wire logic                                csr_wr_en,
   input  wire logic [wepl_pkg::LAG_BITS-1:0]       csr_wr_data,
   // event input, tdata: [31:0] event_time, [39:32] event_label
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [wepl_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // pair results, tdata: [7:0] first_label, [15:8] second_label,
   // [32:16] time_difference, upper bits zero
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [wepl_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   output logic                                     rsp_tlast,
   // tuser: [0] window_overflowed
   output logic                                     rsp_tuser
);
   import wepl_pkg::*;

   // Sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;  // wait for an event transfer
   localparam logic [2:0] ST_READ  = 3'd1;  // issue window memory read
   localparam logic [2:0] ST_CHECK = 3'd2;  // judge the entry read back
   localparam logic [2:0] ST_EMIT1 = 3'd3;  // send (old, new, +age)
   localparam logic [2:0] ST_EMIT2 = 3'd4;  // send mirrored (new, old, -age)
   localparam logic [2:0] ST_STORE = 3'd5;  // write the new event into the ring

   logic [2:0]  state_ff, state_in;
   lag_type     lag_ff, lag_in;
   slot_type    head_ff, head_in;
   count_type   count_ff, count_in;
   logic        overflow_ff, overflow_in;
   slot_type    ptr_ff, ptr_in;
   logic        prune_ff, prune_in;
   time_type    now_ff, now_in;
   label_type   label_ff, label_in;

   // Pair held back until we know whether another one follows (for tlast)
   logic        held_valid_ff, held_valid_in;
   label_type   held_label_ff, held_label_in;
   lag_type     held_age_ff, held_age_in;
   label_type   cand_label_ff, cand_label_in;
   lag_type     cand_age_ff, cand_age_in;
   logic        last_pair_ff, last_pair_in;

   // Window memory: {time, label} per slot
   logic [ENTRY_BITS-1:0] window_mem [WINDOW_DEPTH];
   time_type    rd_time_ff;
   label_type   rd_label_ff;
   logic        mem_rd, mem_wr;
   slot_type    rd_slot, wr_slot;

   time_type    age;
   logic        fits;
   logic        take;
   logic        scan_last;
   logic        out_free, out_load;
   rsp_item_type out_item;
   logic signed [DIFF_BITS-1:0] diff_pos;

   assign req_tready = (state_ff == ST_IDLE);

   assign rd_slot = slot_add(head_ff, COUNT_BITS'(ptr_ff));
   assign wr_slot = (count_ff == COUNT_BITS'(WINDOW_DEPTH)) ? head_ff
                                                             : slot_add(head_ff, count_ff);

   // Wrapped age of the entry just read; only ages within the lag are paired
   assign age       = now_ff - rd_time_ff;
   assign fits      = (age <= time_type'(lag_ff));
   assign take      = (rd_label_ff != '0) && fits;
   assign scan_last = ((COUNT_BITS'(ptr_ff) + COUNT_BITS'(1)) == count_ff);
   assign diff_pos  = DIFF_BITS'({1'b0, held_age_ff});

   always_comb begin
      state_in      = state_ff;
      lag_in        = lag_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      overflow_in   = overflow_ff;
      ptr_in        = ptr_ff;
      prune_in      = prune_ff;
      now_in        = now_ff;
      label_in      = label_ff;
      held_valid_in = held_valid_ff;
      held_label_in = held_label_ff;
      held_age_in   = held_age_ff;
      cand_label_in = cand_label_ff;
      cand_age_in   = cand_age_ff;
      last_pair_in  = last_pair_ff;
      mem_rd        = 1'b0;
      mem_wr        = 1'b0;
      out_load      = 1'b0;
      out_item      = '0;

      if (csr_wr_en) begin
         lag_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               now_in        = req_tdata[TIME_BITS-1:0];
               label_in      = req_tdata[TIME_BITS +: LABEL_BITS];
               ptr_in        = '0;
               prune_in      = 1'b1;
               held_valid_in = 1'b0;
               state_in      = (count_ff == '0) ? ST_STORE : ST_READ;
            end
         end
         ST_READ: begin
            mem_rd   = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (prune_ff && !fits) begin
               // drop the stale head entry and look at the next one
               head_in  = slot_add(head_ff, COUNT_BITS'(1));
               count_in = count_ff - COUNT_BITS'(1);
               state_in = (count_ff == COUNT_BITS'(1)) ? ST_STORE : ST_READ;
            end else begin
               prune_in = 1'b0;
               if (label_ff == '0) begin
                  state_in = ST_STORE;
               end else if (take && held_valid_ff) begin
                  // flush the held pair first, then this entry becomes held
                  cand_label_in = rd_label_ff;
                  cand_age_in   = age[LAG_BITS-1:0];
                  last_pair_in  = 1'b0;
                  state_in      = ST_EMIT1;
               end else begin
                  if (take) begin
                     held_valid_in = 1'b1;
                     held_label_in = rd_label_ff;
                     held_age_in   = age[LAG_BITS-1:0];
                  end
                  if (scan_last) begin
                     last_pair_in = 1'b1;
                     state_in     = (take || held_valid_ff) ? ST_EMIT1 : ST_STORE;
                  end else begin
                     ptr_in   = ptr_ff + SLOT_BITS'(1);
                     state_in = ST_READ;
                  end
               end
            end
         end
         ST_EMIT1: begin
            if (out_free) begin
               out_load                   = 1'b1;
               out_item.first_label       = held_label_ff;
               out_item.second_label      = label_ff;
               out_item.time_difference   = diff_pos;
               out_item.last_of_run       = 1'b0;
               out_item.window_overflowed = overflow_ff;
               state_in                   = ST_EMIT2;
            end
         end
         ST_EMIT2: begin
            if (out_free) begin
               out_load                   = 1'b1;
               out_item.first_label       = label_ff;
               out_item.second_label      = held_label_ff;
               out_item.time_difference   = -diff_pos;
               out_item.last_of_run       = last_pair_ff;
               out_item.window_overflowed = overflow_ff;
               if (last_pair_ff) begin
                  held_valid_in = 1'b0;
                  state_in      = ST_STORE;
               end else begin
                  held_label_in = cand_label_ff;
                  held_age_in   = cand_age_ff;
                  if (scan_last) begin
                     last_pair_in = 1'b1;
                     state_in     = ST_EMIT1;
                  end else begin
                     ptr_in   = ptr_ff + SLOT_BITS'(1);
                     state_in = ST_READ;
                  end
               end
            end
         end
         ST_STORE: begin
            mem_wr = 1'b1;
            if (count_ff == COUNT_BITS'(WINDOW_DEPTH)) begin
               // full window: overwrite the oldest entry and advance the head
               head_in     = slot_add(head_ff, COUNT_BITS'(1));
               overflow_in = 1'b1;
            end else begin
               count_in = count_ff + COUNT_BITS'(1);
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         lag_ff        <= '0;
         head_ff       <= '0;
         count_ff      <= '0;
         overflow_ff   <= 1'b0;
         ptr_ff        <= '0;
         prune_ff      <= 1'b0;
         held_valid_ff <= 1'b0;
         last_pair_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lag_ff        <= lag_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         overflow_ff   <= overflow_in;
         ptr_ff        <= ptr_in;
         prune_ff      <= prune_in;
         held_valid_ff <= held_valid_in;
         last_pair_ff  <= last_pair_in;
      end
   end

   // Payload registers: no reset
   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      label_ff      <= label_in;
      held_label_ff <= held_label_in;
      held_age_ff   <= held_age_in;
      cand_label_ff <= cand_label_in;
      cand_age_ff   <= cand_age_in;
   end

   // Window memory, registered read
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         window_mem[wr_slot] <= {now_ff, label_ff};
      end
      if (mem_rd) begin
         {rd_time_ff, rd_label_ff} <= window_mem[rd_slot];
      end
   end

   wepl_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .item       (out_item),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // A held pair never survives past the end of an event
   a_held_clear_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !held_valid_ff)
      else $error("held pair left over at idle");

   // Window fill never exceeds the ring depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(WINDOW_DEPTH))
      else $error("window count beyond depth");

   // Scan offset stays inside the occupied part of the ring
   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_READ) || (state_ff == ST_CHECK)) |-> (COUNT_BITS'(ptr_ff) < count_ff))
      else $error("scan offset outside window");

   // Results are produced only by the emit states
   a_emit_source: assert property (@(posedge clock) disable iff (reset)
      out_load |-> ((state_ff == ST_EMIT1) || (state_ff == ST_EMIT2)))
      else $error("result loaded outside emit");

   // The overflow flag is sticky
   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |=> overflow_ff)
      else $error("overflow flag cleared");

endmodule

`default_nettype wire

// ===== design/wepl_out_stage.sv =====
// Result output register: holds one pair result until the downstream transfer.
// Depends on wepl_pkg (rsp_item_type, field widths).
`default_nettype none

module wepl_out_stage (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                load,
   input  wire wepl_pkg::rsp_item_type              item,
   output logic                                     free,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [7:0] first_label, [15:8] second_label, [32:16] time_difference, rest zero
   output logic [wepl_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   output logic                                     rsp_tlast,
   // [0] window_overflowed
   output logic                                     rsp_tuser
);
   import wepl_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({item_ff.time_difference,
                                      item_ff.second_label,
                                      item_ff.first_label});
   assign rsp_tlast  = item_ff.last_of_run;
   assign rsp_tuser  = item_ff.window_overflowed;

endmodule

`default_nettype wire
